// File: rtl/t2u_pkg.sv
// ----------------------------------------------------------------------------
// t2u_pkg: shared types and constants of the text stream line decoder
// Holds encodings, result kinds, internal command format and the code point
// constants used by the front (mark sniffing) and the back (decoding).
// ----------------------------------------------------------------------------
package t2u_pkg;

  // Queue depths
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 4;

  // Text encodings, as held in the default encoding register
  typedef enum logic [1:0] {
    ENC_RAW  = 2'd0,
    ENC_UTF8 = 2'd1,
    ENC_LE16 = 2'd2,
    ENC_BE16 = 2'd3
  } enc_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_UNIT    = 2'd0,
    KIND_EOL     = 2'd1,
    KIND_EOS     = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_e;

  // Input opcodes
  typedef enum logic {
    OPC_DATA = 1'b0,
    OPC_EOS  = 1'b1
  } opc_e;

  // Mark sniffing phases
  typedef enum logic [1:0] {
    SNIFF_FIRST  = 2'd0,
    SNIFF_SECOND = 2'd1,
    SNIFF_THIRD  = 2'd2,
    SNIFF_DONE   = 2'd3
  } sniff_e;

  // Commands from front to back
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_MARK = 2'd1,
    CMD_EOS  = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic       plain;  // start the stream without a mark before this byte
    enc_e       enc;    // encoding selected by a mark
    logic [7:0] data;
    logic       eoi;    // last command of the input transaction
  } cmd_t;

  typedef struct packed {
    logic [15:0] unit;
    kind_e       kind;
    logic        rep;
    logic        last;
  } res_t;

  // Byte order mark bytes
  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;
  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;

  // Code point constants
  localparam logic [20:0] CP_CR        = 21'd13;
  localparam logic [20:0] CP_LF        = 21'd10;
  localparam logic [20:0] CP_SUPP_BASE = 21'h10000;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [15:0] SURR_HIGH    = 16'hD800;
  localparam logic [15:0] SURR_LOW     = 16'hDC00;
  localparam logic [15:0] CHAR_QMARK   = 16'h003F;

  function automatic cmd_t mk_cmd(cmd_op_e op, logic plain, enc_e enc,
                                  logic [7:0] data, logic eoi);
    cmd_t c;
    c.op    = op;
    c.plain = plain;
    c.enc   = enc;
    c.data  = data;
    c.eoi   = eoi;
    return c;
  endfunction

endpackage

// File: rtl/t2u_fifo.sv
// ----------------------------------------------------------------------------
// t2u_fifo: small synchronous queue
// Register based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module t2u_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/t2u_front.sv
// ----------------------------------------------------------------------------
// t2u_front: byte order mark sniffer
// Accepts input bytes, tracks the mark check at stream start and turns each
// input transaction into up to three decoder commands, replaying held bytes.
// ----------------------------------------------------------------------------
module t2u_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                opcode_i,
  input  logic [7:0]          in_byte_i,
  output logic                cmd_push_o,
  output t2u_pkg::cmd_t       cmd_o,
  input  logic                cmd_full_i
);

  import t2u_pkg::*;

  sniff_e     phase_q, phase_d;
  logic [7:0] s0_q, s0_d;
  logic [7:0] s1_q, s1_d;
  cmd_t       pend_q [3];
  cmd_t       pend_d [3];
  logic [1:0] pend_cnt_q, pend_cnt_d;

  logic       accept;
  logic       is_eos;
  cmd_t       l0, l1, l2;
  logic [1:0] lcnt;

  // Take a new transaction once the previous command list drains this cycle
  assign full_o     = !((pend_cnt_q == 2'd0) || ((pend_cnt_q == 2'd1) && !cmd_full_i));
  assign accept     = push_i && !full_o;
  assign is_eos     = (opcode_i == OPC_EOS);
  assign cmd_push_o = (pend_cnt_q != 2'd0) && !cmd_full_i;
  assign cmd_o      = pend_q[0];

  // Sniff phase and command list of the accepted transaction
  always_comb begin
    phase_d = phase_q;
    s0_d    = s0_q;
    s1_d    = s1_q;
    l0      = mk_cmd(CMD_EOS, 1'b0, ENC_RAW, 8'h00, 1'b0);
    l1      = l0;
    l2      = l0;
    lcnt    = 2'd0;
    if (accept) begin
      if (is_eos) begin
        // Replay held bytes, then close the stream
        phase_d = SNIFF_FIRST;
        case (phase_q)
          SNIFF_SECOND: begin
            l0   = mk_cmd(CMD_BYTE, 1'b1, ENC_RAW, s0_q, 1'b0);
            l1   = mk_cmd(CMD_EOS, 1'b0, ENC_RAW, 8'h00, 1'b1);
            lcnt = 2'd2;
          end
          SNIFF_THIRD: begin
            l0   = mk_cmd(CMD_BYTE, 1'b1, ENC_RAW, s0_q, 1'b0);
            l1   = mk_cmd(CMD_BYTE, 1'b0, ENC_RAW, s1_q, 1'b0);
            l2   = mk_cmd(CMD_EOS, 1'b0, ENC_RAW, 8'h00, 1'b1);
            lcnt = 2'd3;
          end
          default: begin
            l0   = mk_cmd(CMD_EOS, 1'b0, ENC_RAW, 8'h00, 1'b1);
            lcnt = 2'd1;
          end
        endcase
      end else begin
        case (phase_q)
          SNIFF_FIRST: begin
            s0_d    = in_byte_i;
            phase_d = SNIFF_SECOND;
          end
          SNIFF_SECOND: begin
            if (s0_q == BOM_FF && in_byte_i == BOM_FE) begin
              l0      = mk_cmd(CMD_MARK, 1'b0, ENC_LE16, 8'h00, 1'b1);
              lcnt    = 2'd1;
              phase_d = SNIFF_DONE;
            end else if (s0_q == BOM_FE && in_byte_i == BOM_FF) begin
              l0      = mk_cmd(CMD_MARK, 1'b0, ENC_BE16, 8'h00, 1'b1);
              lcnt    = 2'd1;
              phase_d = SNIFF_DONE;
            end else if (s0_q == BOM_EF && in_byte_i == BOM_BB) begin
              s1_d    = in_byte_i;
              phase_d = SNIFF_THIRD;
            end else begin
              l0      = mk_cmd(CMD_BYTE, 1'b1, ENC_RAW, s0_q, 1'b0);
              l1      = mk_cmd(CMD_BYTE, 1'b0, ENC_RAW, in_byte_i, 1'b1);
              lcnt    = 2'd2;
              phase_d = SNIFF_DONE;
            end
          end
          SNIFF_THIRD: begin
            phase_d = SNIFF_DONE;
            if (in_byte_i == BOM_BF) begin
              l0   = mk_cmd(CMD_MARK, 1'b0, ENC_UTF8, 8'h00, 1'b1);
              lcnt = 2'd1;
            end else begin
              l0   = mk_cmd(CMD_BYTE, 1'b1, ENC_RAW, s0_q, 1'b0);
              l1   = mk_cmd(CMD_BYTE, 1'b0, ENC_RAW, s1_q, 1'b0);
              l2   = mk_cmd(CMD_BYTE, 1'b0, ENC_RAW, in_byte_i, 1'b1);
              lcnt = 2'd3;
            end
          end
          default: begin
            l0   = mk_cmd(CMD_BYTE, 1'b0, ENC_RAW, in_byte_i, 1'b1);
            lcnt = 2'd1;
          end
        endcase
      end
    end
  end

  // Load a new command list or shift out the head command
  always_comb begin
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    if (accept) begin
      pend_d[0]  = l0;
      pend_d[1]  = l1;
      pend_d[2]  = l2;
      pend_cnt_d = lcnt;
    end else if (cmd_push_o) begin
      pend_d[0]  = pend_q[1];
      pend_d[1]  = pend_q[2];
      pend_cnt_d = pend_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q   <= s0_d;
    s1_q   <= s1_d;
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= SNIFF_FIRST;
      pend_cnt_q <= 2'd0;
    end else begin
      phase_q    <= phase_d;
      pend_cnt_q <= pend_cnt_d;
    end
  end

`ifndef SYNTHESIS
  // An end of stream restarts the mark check
  a_eos_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_eos |=> phase_q == SNIFF_FIRST)
    else $error("front: end of stream did not restart sniffing");

  // The third sniffed byte always ends the mark check
  a_third_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_eos && phase_q == SNIFF_THIRD |=> phase_q == SNIFF_DONE)
    else $error("front: sniffing did not end after the third byte");

  // Hold the input while more than one command waits
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q > 2'd1 |-> full_o)
    else $error("front: input open with several commands pending");
`endif

endmodule

// File: rtl/t2u_back.sv
// ----------------------------------------------------------------------------
// t2u_back: text decoder
// Executes front commands: decodes raw, UTF-8 and 16-bit bytes into UTF-16
// results, splits surrogate pairs into a high and a low result and marks
// each transaction's final result through a one-entry holding register.
// ----------------------------------------------------------------------------
module t2u_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  t2u_pkg::enc_e       default_enc_i,
  input  t2u_pkg::cmd_t       cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  output logic                res_push_o,
  output t2u_pkg::res_t       res_o,
  input  logic                res_full_i
);

  import t2u_pkg::*;

  // Decoder state
  enc_e        mode_q, mode_d;
  logic        mark_q, mark_d;
  logic [20:0] acc_q, acc_d;
  logic [1:0]  cont_q, cont_d;
  logic [7:0]  plow_q, plow_d;
  logic        half_q, half_d;
  logic        skip_q, skip_d;
  logic        sur_q, sur_d;
  logic [9:0]  slow_q, slow_d;

  // Holding register for the newest result
  logic        h_vld_q, h_vld_d;
  logic        h_fin_q, h_fin_d;
  logic [15:0] h_unit_q, h_unit_d;
  kind_e       h_kind_q, h_kind_d;
  logic        h_rep_q, h_rep_d;

  logic        step;
  logic        e_step;
  logic        r_vld;
  logic [15:0] r_unit;
  kind_e       r_kind;
  logic        r_rep;
  logic        cp_vld;
  logic [20:0] cp;
  logic [20:0] acc_nx;
  logic [20:0] v;
  enc_e        eff_mode;
  logic        eff_mark;
  logic [7:0]  b;

  assign step = !res_full_i && !cmd_empty_i;
  assign b    = cmd_i.data;

  // Execute one command, or the low half of a surrogate pair
  always_comb begin
    mode_d    = mode_q;
    mark_d    = mark_q;
    acc_d     = acc_q;
    cont_d    = cont_q;
    plow_d    = plow_q;
    half_d    = half_q;
    skip_d    = skip_q;
    sur_d     = sur_q;
    slow_d    = slow_q;
    r_vld     = 1'b0;
    r_unit    = 16'h0000;
    r_kind    = KIND_UNIT;
    r_rep     = 1'b0;
    e_step    = 1'b0;
    cmd_pop_o = 1'b0;
    cp_vld    = 1'b0;
    cp        = '0;
    acc_nx    = '0;
    v         = '0;
    eff_mode  = mode_q;
    eff_mark  = mark_q;
    if (step) begin
      cmd_pop_o = 1'b1;
      e_step    = cmd_i.eoi;
      if (sur_q) begin
        r_vld  = 1'b1;
        r_unit = SURR_LOW | {6'b0, slow_q};
        sur_d  = 1'b0;
      end else begin
        case (cmd_i.op)
          CMD_MARK: begin
            mode_d = cmd_i.enc;
            mark_d = 1'b1;
          end
          CMD_EOS: begin
            mode_d = default_enc_i;
            mark_d = 1'b0;
            acc_d  = '0;
            cont_d = 2'd0;
            half_d = 1'b0;
            r_vld  = 1'b1;
            r_kind = KIND_EOS;
          end
          CMD_BYTE: begin
            if (cmd_i.plain) begin
              eff_mode = default_enc_i;
              eff_mark = 1'b0;
            end
            mode_d = eff_mode;
            mark_d = eff_mark;
            if (!skip_q) begin
              case (eff_mode)
                ENC_RAW: begin
                  cp_vld = 1'b1;
                  cp     = {13'b0, b};
                end
                ENC_LE16, ENC_BE16: begin
                  if (!half_q) begin
                    plow_d = b;
                    half_d = 1'b1;
                  end else begin
                    half_d = 1'b0;
                    cp_vld = 1'b1;
                    cp     = (eff_mode == ENC_LE16) ? {5'b0, b, plow_q} : {5'b0, plow_q, b};
                  end
                end
                ENC_UTF8: begin
                  if (cont_q != 2'd0) begin
                    // Continuation: append six payload bits
                    acc_nx = {acc_q[14:0], b[5:0]};
                    acc_d  = acc_nx;
                    cont_d = cont_q - 2'd1;
                    if (cont_q == 2'd1) begin
                      cp_vld = 1'b1;
                      cp     = acc_nx;
                    end
                  end else if (!b[7]) begin
                    cp_vld = 1'b1;
                    cp     = {13'b0, b};
                  end else if (b[7:5] == 3'b110) begin
                    acc_d  = {16'b0, b[4:0]};
                    cont_d = 2'd1;
                  end else if (b[7:4] == 4'b1110) begin
                    acc_d  = {17'b0, b[3:0]};
                    cont_d = 2'd2;
                  end else if (b[7:3] == 5'b11110) begin
                    acc_d  = {18'b0, b[2:0]};
                    cont_d = 2'd3;
                  end else if (eff_mark) begin
                    r_vld  = 1'b1;
                    r_unit = CHAR_QMARK;
                    r_rep  = 1'b1;
                  end else begin
                    // Bad lead without a mark: fall back to raw, drop the line
                    r_vld  = 1'b1;
                    r_kind = KIND_DISCARD;
                    mode_d = ENC_RAW;
                    acc_d  = '0;
                    cont_d = 2'd0;
                    skip_d = 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
          default: ;
        endcase

        // Map a finished code point onto results
        if (cp_vld) begin
          if (cp == CP_CR) begin
            r_vld = 1'b0;
          end else if (cp == CP_LF) begin
            r_vld  = 1'b1;
            r_kind = KIND_EOL;
          end else if (cp < CP_SUPP_BASE) begin
            r_vld  = 1'b1;
            r_unit = cp[15:0];
          end else if (cp <= CP_MAX) begin
            // High surrogate now, hold the command for the low half
            v         = cp - CP_SUPP_BASE;
            r_vld     = 1'b1;
            r_unit    = SURR_HIGH | {6'b0, v[19:10]};
            sur_d     = 1'b1;
            slow_d    = v[9:0];
            cmd_pop_o = 1'b0;
            e_step    = 1'b0;
          end else begin
            r_vld  = 1'b1;
            r_unit = CHAR_QMARK;
            r_rep  = 1'b1;
          end
        end
      end
      if (cmd_pop_o && cmd_i.eoi) begin
        skip_d = 1'b0;
      end
    end
  end

  // Release the held result once its successor or the transaction end is known
  assign res_push_o = !res_full_i && h_vld_q && (r_vld || e_step || h_fin_q);
  assign res_o      = '{unit: h_unit_q, kind: h_kind_q, rep: h_rep_q,
                        last: h_fin_q || (e_step && !r_vld)};

  always_comb begin
    h_vld_d  = h_vld_q;
    h_fin_d  = h_fin_q;
    h_unit_d = h_unit_q;
    h_kind_d = h_kind_q;
    h_rep_d  = h_rep_q;
    if (r_vld) begin
      h_vld_d  = 1'b1;
      h_fin_d  = e_step;
      h_unit_d = r_unit;
      h_kind_d = r_kind;
      h_rep_d  = r_rep;
    end else if (res_push_o) begin
      h_vld_d = 1'b0;
      h_fin_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    plow_q   <= plow_d;
    slow_q   <= slow_d;
    h_unit_q <= h_unit_d;
    h_kind_q <= h_kind_d;
    h_rep_q  <= h_rep_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ENC_RAW;
      mark_q  <= 1'b0;
      acc_q   <= '0;
      cont_q  <= 2'd0;
      half_q  <= 1'b0;
      skip_q  <= 1'b0;
      sur_q   <= 1'b0;
      h_vld_q <= 1'b0;
      h_fin_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      mark_q  <= mark_d;
      acc_q   <= acc_d;
      cont_q  <= cont_d;
      half_q  <= half_d;
      skip_q  <= skip_d;
      sur_q   <= sur_d;
      h_vld_q <= h_vld_d;
      h_fin_q <= h_fin_d;
    end
  end

`ifndef SYNTHESIS
  // Surrogate pairs only come out of UTF-8 decoding
  a_sur_utf8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sur_q |-> mode_q == ENC_UTF8)
    else $error("back: surrogate pending outside UTF-8 mode");

  // Line dropping only follows a fallback to raw bytes
  a_skip_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> mode_q == ENC_RAW && !mark_q)
    else $error("back: dropping bytes while not in raw mode");

  // A final flag never stands without a held result
  a_fin_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_fin_q |-> h_vld_q)
    else $error("back: final flag set on an empty holding register");
`endif

endmodule

// File: rtl/text_stream_to_utf16_line_decoder_unit.sv
// Text stream to UTF-16 line decoder. Bytes enter through a push/full queue
// port and UTF-16 code units, end-of-line, end-of-stream and discard-line
// results leave through an empty/pop queue port, with last set on the final
// result of each input transaction. One byte is taken per cycle while full is
// low; the byte that ends a failed byte order mark check, and an end of stream
// during that check, expand into up to three decoder commands and stall the
// input while they drain. The decoder retires one command per cycle and emits
// one result per cycle while commands wait and results have room; a surrogate
// pair (code point above 0xFFFF) holds its command for the low half. A command
// queue of CmdDepth entries and a result queue of ResDepth entries let each
// side stall on its own; the default encoding register (0 raw, 1 UTF-8, 2 LE16,
// 3 BE16) is always ready and applies when a stream starts without a mark.
// ----------------------------------------------------------------------------
// text_stream_to_utf16_line_decoder_unit: top level
// Joins the mark sniffer, command queue, decoder and result queue.
// ----------------------------------------------------------------------------
module text_stream_to_utf16_line_decoder_unit #(
  parameter int unsigned CmdDepth = t2u_pkg::CMD_DEPTH,
  parameter int unsigned ResDepth = t2u_pkg::RES_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        opcode_i,
  input  logic [7:0]  in_byte_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] code_unit_o,
  output logic [1:0]  kind_o,
  output logic        replaced_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  import t2u_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(res_t);

  enc_e            default_enc_q;
  logic            cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t            front_cmd, back_cmd;
  logic [CmdW-1:0] cmd_rdata;
  logic            res_push, res_full;
  res_t            back_res, out_res;
  logic [ResW-1:0] res_rdata;

  // Default encoding register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_enc_q <= ENC_RAW;
    end else if (cfg_valid_i && cfg_ready_o) begin
      default_enc_q <= enc_e'(cfg_data_i);
    end
  end

  t2u_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .opcode_i   (opcode_i),
    .in_byte_i  (in_byte_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd),
    .cmd_full_i (cmd_full)
  );

  t2u_fifo #(
    .Depth (CmdDepth),
    .Width (CmdW)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign back_cmd = cmd_t'(cmd_rdata);

  t2u_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .default_enc_i (default_enc_q),
    .cmd_i         (back_cmd),
    .cmd_empty_i   (cmd_empty),
    .cmd_pop_o     (cmd_pop),
    .res_push_o    (res_push),
    .res_o         (back_res),
    .res_full_i    (res_full)
  );

  t2u_fifo #(
    .Depth (ResDepth),
    .Width (ResW)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (res_rdata),
    .empty_o (empty_o)
  );

  // Drive result fields
  assign out_res     = res_t'(res_rdata);
  assign code_unit_o = out_res.unit;
  assign kind_o      = out_res.kind;
  assign replaced_o  = out_res.rep;
  assign last_o      = out_res.last;

endmodule
